// File: src/dps_pkg.sv
// shared types and constants for the diffuse pixel shader
// no dependencies
`timescale 1ns / 1ps

package dps_pkg;

	localparam int NUM_BITS = 15;
	localparam int WIDE_W = 64;

	localparam logic [2:0] REG_LIGHT_X = 3'd0;
	localparam logic [2:0] REG_LIGHT_Y = 3'd1;
	localparam logic [2:0] REG_LIGHT_Z = 3'd2;
	localparam logic [2:0] REG_USE_TEXTURE = 3'd3;
	localparam logic [2:0] REG_MIN_INTENSITY = 3'd4;

	localparam logic [15:0] Q15_ONE = 16'd32768;
	localparam logic [7:0] GRAY_LEVEL = 8'd128;
	localparam logic [9:0] COLOR_BIAS = 10'd5;
	localparam logic [9:0] COLOR_MAX = 10'd255;

	localparam logic signed [15:0] LIGHT_X_RST = 16'sd0;
	localparam logic signed [15:0] LIGHT_Y_RST = 16'sd0;
	localparam logic signed [15:0] LIGHT_Z_RST = -16'sd16384;
	localparam logic [15:0] MIN_INTENSITY_RST = 16'd6554;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} light_t;

	// one beat travelling down the square-root cell row
	typedef struct packed {
		logic valid;
		logic keep;
		logic sat;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [WIDE_W-1:0] rem;
		logic [WIDE_W-1:0] acc;
		logic [WIDE_W-1:0] step;
		logic [NUM_BITS-1:0] q;
	} cell_t;

endpackage

// File: src/dps_in_if.sv
// input channel of the diffuse pixel shader: normal and texel color
// depends on nothing
`timescale 1ns / 1ps

interface dps_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic signed [15:0] normal_z;
	logic [7:0] texel_red;
	logic [7:0] texel_green;
	logic [7:0] texel_blue;

	modport source (output valid, normal_x, normal_y, normal_z,
		texel_red, texel_green, texel_blue, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z,
		texel_red, texel_green, texel_blue, output ready);
endinterface

// File: src/dps_out_if.sv
// output channel of the diffuse pixel shader: keep flag and shaded color
// depends on nothing
`timescale 1ns / 1ps

interface dps_out_if;
	logic valid;
	logic ready;
	logic keep_pixel;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, keep_pixel, out_red, out_green, out_blue,
		input ready);
	modport sink (input valid, keep_pixel, out_red, out_green, out_blue,
		output ready);
endinterface

// File: src/dps_front.sv
// front pipeline: dot product, squared length, squared dot, cell row seed
// depends on dps_pkg
`timescale 1ns / 1ps

module dps_front (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  logic signed [15:0] nx,
	input  logic signed [15:0] ny,
	input  logic signed [15:0] nz,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  dps_pkg::light_t light,
	output dps_pkg::cell_t head
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic [23:0] tex_s1, tex_s2, tex_s3, tex_s4;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [31:0] sx_s1, sy_s1, sz_s1;
	logic signed [33:0] dot_s2;
	logic [31:0] len_s2, len_s3, len_s4;
	logic keep_s3, keep_s4;
	logic [31:0] d_s3;
	logic [31:0] hh_s4, hl_s4, ll_s4;
	logic signed [33:0] neg_dot;
	logic [63:0] dd;
	logic [63:0] len_sh;

	assign neg_dot = -dot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= nx * light.x;
			py_s1 <= ny * light.y;
			pz_s1 <= nz * light.z;
			sx_s1 <= 32'(nx * nx);
			sy_s1 <= 32'(ny * ny);
			sz_s1 <= 32'(nz * nz);
			tex_s1 <= {red, green, blue};

			dot_s2 <= 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
			len_s2 <= sx_s1 + sy_s1 + sz_s1;
			tex_s2 <= tex_s1;

			// discard on zero length or back-lit
			keep_s3 <= (len_s2 != 32'd0) && (dot_s2[33] || (dot_s2 == 34'sd0));
			d_s3 <= neg_dot[31:0];
			len_s3 <= len_s2;
			tex_s3 <= tex_s2;

			// split squaring of the 32-bit dot into 16-bit partial products
			hh_s4 <= d_s3[31:16] * d_s3[31:16];
			hl_s4 <= d_s3[31:16] * d_s3[15:0];
			ll_s4 <= d_s3[15:0] * d_s3[15:0];
			keep_s4 <= keep_s3;
			len_s4 <= len_s3;
			tex_s4 <= tex_s3;
		end
	end

	// seed of the cell row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head <= '0;
		end else if (en) begin
			head.valid <= v_s4;
			head.keep <= keep_s4;
			head.sat <= dd >= len_sh;
			head.red <= tex_s4[23:16];
			head.green <= tex_s4[15:8];
			head.blue <= tex_s4[7:0];
			head.rem <= {dd[61:0], 2'b00};
			head.acc <= '0;
			head.step <= len_sh;
			head.q <= '0;
		end
	end

	always_comb begin
		dd = {hh_s4, 32'd0} + {15'd0, hl_s4, 17'd0} + {32'd0, ll_s4};
		len_sh = {4'd0, len_s4, 28'd0};
	end

endmodule

// File: src/dps_cell.sv
// one cell of the square-root row: decides one intensity bit per beat
// depends on dps_pkg
`timescale 1ns / 1ps

module dps_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  dps_pkg::cell_t prev,
	output dps_pkg::cell_t nxt
);

	logic [dps_pkg::WIDE_W-1:0] trial;
	logic take;

	// trial holds 2^(b+1)*q*s + 2^(2b)*s for the bit under test
	assign trial = prev.acc + prev.step;
	assign take = prev.rem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt <= '0;
		end else if (en) begin
			nxt.valid <= prev.valid;
			nxt.keep <= prev.keep;
			nxt.sat <= prev.sat;
			nxt.red <= prev.red;
			nxt.green <= prev.green;
			nxt.blue <= prev.blue;
			nxt.rem <= take ? prev.rem - trial : prev.rem;
			nxt.acc <= (prev.acc >> 1) + (take ? prev.step : '0);
			nxt.step <= prev.step >> 2;
			nxt.q <= {prev.q[dps_pkg::NUM_BITS-2:0], take};
		end
	end

endmodule

// File: src/diffuse_pixel_shader.sv
// top level of the diffuse pixel shader: registers, front, cell row, color stage
// depends on dps_pkg, dps_in_if, dps_out_if, dps_front, dps_cell
`timescale 1ns / 1ps

// Lambert diffuse shading of one pixel per clock. Each beat on pixel_in carries
// a normal and a texel color; each beat on pixel_out carries keep_pixel and the
// shaded color, in input order, after the front, the cell row and the output
// register. A new pixel is accepted every cycle; the whole pipeline holds while
// a result waits at the output. The rate is set by the row of 15 square-root
// cells, one intensity bit each, which all advance together. The user must write
// configuration registers (light vector, texture enable, minimum intensity)
// via the cfg port only while the pipeline is empty; the block does not check.

module diffuse_pixel_shader (
	input  logic clk,
	input  logic arst_n,
	dps_in_if.sink pixel_in,
	dps_out_if.source pixel_out,
	input  logic cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);

	dps_pkg::light_t light_q;
	logic use_texture_q;
	logic [15:0] min_intensity_q;

	logic en;
	dps_pkg::cell_t chain [0:dps_pkg::NUM_BITS];

	logic out_valid_q;
	logic keep_q;
	logic [7:0] red_q, green_q, blue_q;

	// intensity and color of the beat leaving the cell row
	logic [15:0] raw_i, clamp_i, inten;
	logic [7:0] base_r, base_g, base_b;
	logic [23:0] prod_r, prod_g, prod_b;
	logic [9:0] sum_r, sum_g, sum_b;
	dps_pkg::cell_t tail;

	// whole pipeline moves when the output slot is free or being taken
	assign en = !out_valid_q || pixel_out.ready;
	assign pixel_in.ready = en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q.x <= dps_pkg::LIGHT_X_RST;
			light_q.y <= dps_pkg::LIGHT_Y_RST;
			light_q.z <= dps_pkg::LIGHT_Z_RST;
			use_texture_q <= 1'b0;
			min_intensity_q <= dps_pkg::MIN_INTENSITY_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				dps_pkg::REG_LIGHT_X: light_q.x <= cfg_data;
				dps_pkg::REG_LIGHT_Y: light_q.y <= cfg_data;
				dps_pkg::REG_LIGHT_Z: light_q.z <= cfg_data;
				dps_pkg::REG_USE_TEXTURE: use_texture_q <= cfg_data[0];
				dps_pkg::REG_MIN_INTENSITY: min_intensity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// dot product, squared length and seed of the cell row
	dps_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(pixel_in.valid),
		.nx(pixel_in.normal_x),
		.ny(pixel_in.normal_y),
		.nz(pixel_in.normal_z),
		.red(pixel_in.texel_red),
		.green(pixel_in.texel_green),
		.blue(pixel_in.texel_blue),
		.light(light_q),
		.head(chain[0])
	);

	// floor of 2*D/sqrt(S), most significant bit first, one bit per cell
	for (genvar i = 0; i < dps_pkg::NUM_BITS; i++) begin : g_cell
		dps_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.prev(chain[i]),
			.nxt(chain[i+1])
		);
	end

	assign tail = chain[dps_pkg::NUM_BITS];

	always_comb begin
		// saturated pixels skip the cell result
		raw_i = tail.sat ? dps_pkg::Q15_ONE : {1'b0, tail.q};
		// clamp to the minimum first, then cap at one
		clamp_i = (raw_i < min_intensity_q) ? min_intensity_q : raw_i;
		inten = (clamp_i > dps_pkg::Q15_ONE) ? dps_pkg::Q15_ONE : clamp_i;

		base_r = use_texture_q ? tail.red : dps_pkg::GRAY_LEVEL;
		base_g = use_texture_q ? tail.green : dps_pkg::GRAY_LEVEL;
		base_b = use_texture_q ? tail.blue : dps_pkg::GRAY_LEVEL;

		prod_r = base_r * inten;
		prod_g = base_g * inten;
		prod_b = base_b * inten;

		sum_r = {1'b0, prod_r[23:15]} + dps_pkg::COLOR_BIAS;
		sum_g = {1'b0, prod_g[23:15]} + dps_pkg::COLOR_BIAS;
		sum_b = {1'b0, prod_b[23:15]} + dps_pkg::COLOR_BIAS;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_q <= tail.keep;
			// discarded pixels carry black
			red_q <= !tail.keep ? 8'd0 :
				(sum_r > dps_pkg::COLOR_MAX) ? dps_pkg::COLOR_MAX[7:0] : sum_r[7:0];
			green_q <= !tail.keep ? 8'd0 :
				(sum_g > dps_pkg::COLOR_MAX) ? dps_pkg::COLOR_MAX[7:0] : sum_g[7:0];
			blue_q <= !tail.keep ? 8'd0 :
				(sum_b > dps_pkg::COLOR_MAX) ? dps_pkg::COLOR_MAX[7:0] : sum_b[7:0];
		end
	end

	assign pixel_out.valid = out_valid_q;
	assign pixel_out.keep_pixel = keep_q;
	assign pixel_out.out_red = red_q;
	assign pixel_out.out_green = green_q;
	assign pixel_out.out_blue = blue_q;

endmodule

// File: test/dps_test_if.sv
// testbench-side channel interfaces are the block's own; this file holds the
// config write bundle used between the stimulus top and the checker
// depends on nothing
`timescale 1ns / 1ps

interface dps_cfg_if;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	modport source (output cfg_write, cfg_index, cfg_data);
	modport sink (input cfg_write, cfg_index, cfg_data);
endinterface

// File: test/dps_checker.sv
// shading predictor and scoreboard for the diffuse pixel shader
// depends on dps_pkg, dps_in_if, dps_out_if, dps_cfg_if
`timescale 1ns / 1ps

module dps_checker (
	input logic clk,
	input logic arst_n,
	dps_in_if.sink pixel_in,
	dps_out_if.sink pixel_out,
	dps_cfg_if.sink cfg,
	output int errors,
	output int pending,
	output int kept,
	output int dropped
);

	typedef struct packed {
		logic keep;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	logic signed [15:0] lx, ly, lz;
	logic tex_on;
	logic [15:0] min_i;
	shade_t shade_q[$];

	function automatic logic [7:0] tint(input logic [7:0] base, input longint inten);
		longint c;
		c = ((longint'(base) * inten) >>> 15) + longint'(dps_pkg::COLOR_BIAS);
		return (c > longint'(dps_pkg::COLOR_MAX)) ? dps_pkg::COLOR_MAX[7:0] : c[7:0];
	endfunction

	function automatic shade_t shade(input logic signed [15:0] nx, ny, nz,
			input logic [7:0] r, g, b);
		shade_t o;
		longint dot, s, d, lim, q, t, inten;
		logic [7:0] br, bg, bb;
		o = '0;
		dot = longint'(nx) * lx + longint'(ny) * ly + longint'(nz) * lz;
		s = longint'(nx) * nx + longint'(ny) * ny + longint'(nz) * nz;
		if (s == 0 || dot > 0) return o;
		d = -dot;
		// d*d up to ~2^63; compare in unsigned
		if (unsigned'(d * d) >= unsigned'(s << 28)) begin
			inten = dps_pkg::Q15_ONE;
		end else begin
			lim = 4 * d * d;
			q = 0;
			for (int bit_i = 14; bit_i >= 0; bit_i--) begin
				t = q | (longint'(1) << bit_i);
				if (unsigned'(t * t * s) <= unsigned'(lim)) q = t;
			end
			inten = q;
		end
		if (inten < min_i) inten = min_i;
		if (inten > dps_pkg::Q15_ONE) inten = dps_pkg::Q15_ONE;
		br = tex_on ? r : dps_pkg::GRAY_LEVEL;
		bg = tex_on ? g : dps_pkg::GRAY_LEVEL;
		bb = tex_on ? b : dps_pkg::GRAY_LEVEL;
		o.keep = 1'b1;
		o.red = tint(br, inten);
		o.green = tint(bg, inten);
		o.blue = tint(bb, inten);
		return o;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		shade_t w;
		if (!arst_n) begin
			lx <= dps_pkg::LIGHT_X_RST;
			ly <= dps_pkg::LIGHT_Y_RST;
			lz <= dps_pkg::LIGHT_Z_RST;
			tex_on <= 1'b0;
			min_i <= dps_pkg::MIN_INTENSITY_RST;
			errors <= 0;
			kept <= 0;
			dropped <= 0;
		end else begin
			if (cfg.cfg_write) begin
				case (cfg.cfg_index)
				dps_pkg::REG_LIGHT_X: lx <= cfg.cfg_data;
				dps_pkg::REG_LIGHT_Y: ly <= cfg.cfg_data;
				dps_pkg::REG_LIGHT_Z: lz <= cfg.cfg_data;
				dps_pkg::REG_USE_TEXTURE: tex_on <= cfg.cfg_data[0];
				dps_pkg::REG_MIN_INTENSITY: min_i <= cfg.cfg_data;
				default: ;
				endcase
			end
			if (pixel_in.valid && pixel_in.ready)
				shade_q.push_back(shade(pixel_in.normal_x, pixel_in.normal_y,
					pixel_in.normal_z, pixel_in.texel_red, pixel_in.texel_green,
					pixel_in.texel_blue));
			if (pixel_out.valid && pixel_out.ready) begin
				if (shade_q.size() == 0) begin
					report("unexpected beat keep", pixel_out.keep_pixel, -1);
				end else begin
					w = shade_q.pop_front();
					if (w.keep) kept <= kept + 1; else dropped <= dropped + 1;
					if (pixel_out.keep_pixel !== w.keep)
						report("keep_pixel", pixel_out.keep_pixel, w.keep);
					if (pixel_out.out_red !== w.red) report("out_red", pixel_out.out_red, w.red);
					if (pixel_out.out_green !== w.green)
						report("out_green", pixel_out.out_green, w.green);
					if (pixel_out.out_blue !== w.blue)
						report("out_blue", pixel_out.out_blue, w.blue);
				end
			end
		end
	end

	assign pending = shade_q.size();

endmodule

// File: test/diffuse_pixel_shader_test.sv
// stimulus and verdict for the diffuse pixel shader
// depends on dps_pkg, dps_in_if, dps_out_if, dps_cfg_if, dps_checker, diffuse_pixel_shader
`timescale 1ns / 1ps

module diffuse_pixel_shader_test;

	localparam int STALL_LIMIT = 2000;   // cycles with no beat before giving up
	localparam int DRAIN_CYCLES = 40;    // more than the pipeline depth
	localparam logic [2:0] REG_UNUSED = 3'd7;   // no register at this index

	logic clk;
	logic arst_n;
	int errors, pending, kept, dropped;
	int idle_cycles;
	bit calm;        // no idling in the last part

	dps_in_if pixel_in ();
	dps_out_if pixel_out ();
	dps_cfg_if cfg ();

	diffuse_pixel_shader dut (
		.clk(clk), .arst_n(arst_n),
		.pixel_in(pixel_in.sink), .pixel_out(pixel_out.source),
		.cfg_write(cfg.cfg_write), .cfg_index(cfg.cfg_index), .cfg_data(cfg.cfg_data)
	);

	dps_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.pixel_in(pixel_in.sink), .pixel_out(pixel_out.sink), .cfg(cfg.sink),
		.errors(errors), .pending(pending), .kept(kept), .dropped(dropped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: count cycles in which no beat moves on either side
	always @(posedge clk) begin
		if (!arst_n || (pixel_in.valid && pixel_in.ready) ||
				(pixel_out.valid && pixel_out.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("diffuse_pixel_shader: mismatch");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, none once the run is calm
	initial begin
		pixel_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				pixel_out.ready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
				@(negedge clk);
			end
			pixel_out.ready <= 1'b1;
			repeat ($urandom_range(1, 20) - 1) @(negedge clk);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg.cfg_write <= 1'b1;
		cfg.cfg_index <= idx;
		cfg.cfg_data <= val;
		@(negedge clk);
		cfg.cfg_write <= 1'b0;
	endtask

	// wait for the pipeline to empty before a register change
	task automatic quiesce();
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one pixel beat, with an optional random gap first
	task automatic send_pixel(input logic [15:0] nx, ny, nz, input logic [7:0] r, g, b);
		if (!calm && $urandom_range(0, 6) == 0) begin
			pixel_in.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		pixel_in.valid <= 1'b1;
		pixel_in.normal_x <= nx;
		pixel_in.normal_y <= ny;
		pixel_in.normal_z <= nz;
		pixel_in.texel_red <= r;
		pixel_in.texel_green <= g;
		pixel_in.texel_blue <= b;
		@(posedge clk);
		while (!pixel_in.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic end_burst();
		pixel_in.valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 5))
		0: return 16'h8000;
		1: return 16'h7fff;
		2: return 16'h0000;
		3: return 16'(int'($urandom_range(0, 15)) - 8);
		default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pixels(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(pick_axis(), pick_axis(), pick_axis(),
				8'($urandom), 8'($urandom), 8'($urandom));
		end_burst();
	endtask

	// light settings: unit axes, diagonals, extremes, non-unit vectors
	task automatic set_light(input logic [15:0] x, y, z);
		write_reg(dps_pkg::REG_LIGHT_X, x);
		write_reg(dps_pkg::REG_LIGHT_Y, y);
		write_reg(dps_pkg::REG_LIGHT_Z, z);
	endtask

	initial begin
		arst_n = 1'b0;
		calm = 1'b0;
		pixel_in.valid = 1'b0;
		pixel_in.normal_x = '0;
		pixel_in.normal_y = '0;
		pixel_in.normal_z = '0;
		pixel_in.texel_red = '0;
		pixel_in.texel_green = '0;
		pixel_in.texel_blue = '0;
		cfg.cfg_write = 1'b0;
		cfg.cfg_index = '0;
		cfg.cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset registers: light along -z, gray base
		send_pixel(16'h0000, 16'h0000, 16'h0000, 8'hff, 8'hff, 8'hff);   // zero normal
		send_pixel(16'h0000, 16'h0000, 16'h7fff, 8'h00, 8'h00, 8'h00);   // facing light
		send_pixel(16'h0000, 16'h0000, 16'h8000, 8'h00, 8'h00, 8'h00);   // back-lit
		send_pixel(16'h7fff, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);   // grazing, dot zero
		send_pixel(16'h8000, 16'h8000, 16'h7fff, 8'h00, 8'h00, 8'h00);
		send_pixel(16'h0001, 16'hffff, 16'h0001, 8'hff, 8'h00, 8'hff);
		send_pixel(16'h8000, 16'h8000, 16'h8000, 8'h55, 8'haa, 8'h55);
		end_burst();
		quiesce();

		// textured, min above one, light non-unit at extremes
		write_reg(dps_pkg::REG_USE_TEXTURE, 16'h0001);
		write_reg(dps_pkg::REG_MIN_INTENSITY, 16'hffff);
		set_light(16'h8000, 16'h8000, 16'h8000);
		send_pixel(16'h7fff, 16'h7fff, 16'h7fff, 8'hff, 8'h00, 8'h80);
		send_pixel(16'h0001, 16'h0001, 16'h0001, 8'h01, 8'hfe, 8'h7f);
		send_pixel(16'h8000, 16'h0000, 16'h0000, 8'haa, 8'h55, 8'hff);
		end_burst();
		quiesce();
		write_reg(dps_pkg::REG_MIN_INTENSITY, 16'h0000);
		set_light(16'h7fff, 16'h7fff, 16'h7fff);
		send_pixel(16'h8000, 16'h8000, 16'h8000, 8'hff, 8'hff, 8'hff);
		send_pixel(16'h8000, 16'h7fff, 16'h0000, 8'hff, 8'hff, 8'hff);   // dot near zero
		send_pixel(16'h0000, 16'h0001, 16'hffff, 8'h10, 8'h20, 8'h30);
		send_pixel(16'hc000, 16'h0000, 16'h0000, 8'hff, 8'h00, 8'hff);
		end_burst();
		quiesce();
		write_reg(dps_pkg::REG_MIN_INTENSITY, 16'h8000);
		send_pixel(16'hc000, 16'h4000, 16'h0000, 8'hff, 8'h01, 8'h80);
		end_burst();
		quiesce();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 12; ph++) begin
			write_reg(dps_pkg::REG_USE_TEXTURE, 16'($urandom_range(0, 1)));
			write_reg(dps_pkg::REG_MIN_INTENSITY,
				(ph % 3 == 0) ? 16'd0 : 16'($urandom_range(0, 32768)));
			case (ph % 4)
			0: set_light(16'h0000, 16'h0000, 16'hc000);
			1: set_light(16'h2d41, 16'h0000, 16'hd2bf);
			2: set_light(16'($urandom), 16'($urandom), 16'($urandom));
			default: set_light(16'h4000, 16'h0000, 16'h0000);
			endcase
			write_reg(REG_UNUSED, 16'hffff);   // ignored by the block
			if (ph >= 10) calm = 1'b1;
			random_pixels(115);
			quiesce();
		end

		$display("covered %0d drawn and %0d discarded pixels over 16 register settings",
			kept, dropped);
		if (errors == 0)
			$display("diffuse_pixel_shader: match");
		else
			$display("diffuse_pixel_shader: mismatch");
		$finish;
	end

endmodule

// File: sim.f
src/dps_pkg.sv
src/dps_in_if.sv
src/dps_out_if.sv
src/dps_front.sv
src/dps_cell.sv
src/diffuse_pixel_shader.sv
test/dps_test_if.sv
test/dps_checker.sv
test/diffuse_pixel_shader_test.sv
